@@ design/convolutional_time_deinterleaver_core_macros.svh @@
// Assertion macros shared by the de-interleaver checker.
`ifndef CONVOLUTIONAL_TIME_DEINTERLEAVER_CORE_MACROS_SVH
`define CONVOLUTIONAL_TIME_DEINTERLEAVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during rst.
`define CTDI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctdi: same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled during rst.
`define CTDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctdi: next-cycle check failed");

`endif

@@ design/ctdi_pkg.sv @@
// Types, constants and the branch map of the time de-interleaver.
package ctdi_pkg;

  localparam int SOFT_W      = 16;
  localparam int CFG_W       = 14;
  localparam int BR_W        = 4;
  localparam int FILL_W      = 5;
  localparam int FILL_DONE   = 16;
  localparam int FRAG_RESET  = 384;

  typedef logic signed [SOFT_W-1:0] soft_t;
  typedef logic        [CFG_W-1:0]  cfg_size_t;
  typedef logic        [BR_W-1:0]   branch_t;

  // Per-transfer control from the sequencer to the datapath
  typedef struct packed {
    logic    wr_en;
    branch_t wr_branch;
    branch_t rd_branch;
    logic    bypass;
    logic    emit;
    logic    last;
  } ctdi_ctl_t;

  // Bit-reversed branch offset for a position within a group of 16
  function automatic branch_t branch_offset(input logic [BR_W-1:0] sel);
    branch_t r;
    case (sel)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd8;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd12;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd10;
      4'd6:    r = 4'd6;
      4'd7:    r = 4'd14;
      4'd8:    r = 4'd1;
      4'd9:    r = 4'd9;
      4'd10:   r = 4'd5;
      4'd11:   r = 4'd13;
      4'd12:   r = 4'd3;
      4'd13:   r = 4'd11;
      4'd14:   r = 4'd7;
      4'd15:   r = 4'd15;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/ctdi_if.sv @@
// Stream and configuration interfaces of the time de-interleaver.
interface ctdi_in_if;
  logic           valid;
  logic           ready;
  ctdi_pkg::soft_t soft_bit;
  modport source (output valid, output soft_bit, input ready);
  modport sink   (input valid, input soft_bit, output ready);
endinterface

interface ctdi_out_if;
  logic           valid;
  logic           ready;
  ctdi_pkg::soft_t soft_bit_out;
  logic           fragment_end;
  modport source (output valid, output soft_bit_out, output fragment_end, input ready);
  modport sink   (input valid, input soft_bit_out, input fragment_end, output ready);
endinterface

interface ctdi_cfg_if;
  logic               valid;
  logic               ready;
  ctdi_pkg::cfg_size_t fragment_size;
  modport source (output valid, output fragment_size, input ready);
  modport sink   (input valid, input fragment_size, output ready);
endinterface

@@ design/ctdi_mem.sv @@
// Branch store: one write port, one read port, registered read data.
module ctdi_mem #(
  parameter int AW = 17,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ctdi_ctrl.sv @@
// Fragment sequencer: position, write branch, fill count and size register.
module ctdi_ctrl #(
  parameter int MAX_FRAGMENT = 8192
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         cfg_we,
  input  ctdi_pkg::cfg_size_t          cfg_size,
  output logic [$clog2(MAX_FRAGMENT)-1:0] pos,
  output ctdi_pkg::ctdi_ctl_t          ctl
);
  import ctdi_pkg::*;

  localparam int PW  = $clog2(MAX_FRAGMENT);
  localparam int SZW = $clog2(MAX_FRAGMENT + 1);
  localparam int XW  = (SZW > CFG_W) ? SZW : CFG_W;
  localparam logic [SZW-1:0] RST_SIZE =
    (FRAG_RESET > MAX_FRAGMENT) ? SZW'(MAX_FRAGMENT) : SZW'(FRAG_RESET);

  logic [SZW-1:0]    size;
  logic [SZW-1:0]    size_next;
  logic [XW-1:0]     cfg_x;
  branch_t           wr_branch;
  logic [FILL_W-1:0] fill;
  logic              last;
  logic              emit;
  branch_t           offset;

  // Clamp the written size to 1..MAX_FRAGMENT
  always_comb begin
    cfg_x = XW'(cfg_size);
    if (cfg_x == '0) begin
      size_next = SZW'(1);
    end else if (cfg_x > XW'(MAX_FRAGMENT)) begin
      size_next = SZW'(MAX_FRAGMENT);
    end else begin
      size_next = SZW'(cfg_x);
    end
  end

  assign last   = (SZW'(pos) + SZW'(1)) >= size;
  assign emit   = (fill == FILL_W'(FILL_DONE));
  assign offset = branch_offset(pos[BR_W-1:0]);

  assign ctl.wr_en     = accept;
  assign ctl.wr_branch = wr_branch;
  assign ctl.rd_branch = wr_branch + offset;
  assign ctl.bypass    = (offset == '0);
  assign ctl.emit      = emit;
  assign ctl.last      = last;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= RST_SIZE;
      pos       <= '0;
      wr_branch <= '0;
      fill      <= '0;
    end else begin
      if (cfg_we) begin
        size <= size_next;
      end
      if (accept) begin
        if (last) begin
          pos       <= '0;
          wr_branch <= wr_branch + branch_t'(1);
          if (!emit) begin
            fill <= fill + FILL_W'(1);
          end
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

endmodule

@@ design/convolutional_time_deinterleaver_core.sv @@
// Top level of the 16-branch convolutional time de-interleaver.
//
//   channel | dir | payload                      | transfer
//   din     | in  | soft_bit                     | valid & ready
//   dout    | out | soft_bit_out, fragment_end   | valid & ready
//   cfg     | in  | fragment_size                | valid & ready (ready always high)
//
// One soft bit per clock sustained while dout is ready; a result passes through stage 1 and the output register.
// Each transfer does one store write and one store read on separate ports.
// The first 16 fragments fill the store and give no results.
// rst is synchronous; counters, size (384) and valids clear, the store does not.
// A stalled dout holds its output register; din stalls once stage 1 is also full.
module convolutional_time_deinterleaver_core #(
  parameter int MAX_FRAGMENT = 8192
) (
  input  logic       clk,
  input  logic       rst,
  ctdi_in_if.sink    din,
  ctdi_out_if.source dout,
  ctdi_cfg_if.sink   cfg
);
  import ctdi_pkg::*;

  localparam int PW = $clog2(MAX_FRAGMENT);
  localparam int AW = BR_W + PW;

  logic          accept;
  logic          adv;
  logic [PW-1:0] pos;
  ctdi_ctl_t     ctl;
  logic [SOFT_W-1:0] rdata;

  logic          s1_valid;
  logic          s1_emit;
  logic          s1_last;
  logic          s1_bypass;
  soft_t         s1_wdata;

  logic          o_valid;
  soft_t         o_data;
  logic          o_last;

  assign adv       = !o_valid || dout.ready;
  assign din.ready = !s1_valid || adv;
  assign accept    = din.valid && din.ready;
  assign cfg.ready = 1'b1;

  ctdi_ctrl #(.MAX_FRAGMENT(MAX_FRAGMENT)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cfg_we   (cfg.valid),
    .cfg_size (cfg.fragment_size),
    .pos      (pos),
    .ctl      (ctl)
  );

  ctdi_mem #(.AW(AW), .DW(SOFT_W)) u_mem (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr ({ctl.wr_branch, pos}),
    .wdata (din.soft_bit),
    .re    (accept),
    .raddr ({ctl.rd_branch, pos}),
    .rdata (rdata)
  );

  // Stage 1: waits on the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit   <= ctl.emit;
      s1_last   <= ctl.last;
      s1_bypass <= ctl.bypass;
      s1_wdata  <= din.soft_bit;
    end
  end

  // Output register; a zero offset returns the bit just written
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_data <= s1_bypass ? s1_wdata : soft_t'(rdata);
      o_last <= s1_last;
    end
  end

  assign dout.valid        = o_valid;
  assign dout.soft_bit_out = o_data;
  assign dout.fragment_end = o_last;

endmodule

@@ design/ctdi_checker.sv @@
// Port-level checker for the time de-interleaver, bound to the top level.
`include "convolutional_time_deinterleaver_core_macros.svh"

module ctdi_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ctdi_pkg::SOFT_W-1:0] out_soft,
  input logic                  out_end
);

  // A held result keeps its valid
  `CTDI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A held result keeps its payload
  `CTDI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_soft) && $stable(out_end))

  // Input stalls only behind a stalled result
  `CTDI_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready)

  // A result after an empty output comes from an accepted input transfer, registered through stage 1
  `CTDI_ASSERT_NOW(a_out_src, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind convolutional_time_deinterleaver_core ctdi_checker u_ctdi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_soft  (dout.soft_bit_out),
  .out_end   (dout.fragment_end)
);

@@ bench/tb_convolutional_time_deinterleaver_core.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the 16-branch time de-interleaver: random stream, stalls, size changes.
module tb_convolutional_time_deinterleaver_core;
  import ctdi_pkg::*;

  localparam int MAX_FRAG = 8192;

  typedef struct {
    soft_t soft_bit_out;
    logic  fragment_end;
  } deint_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctdi_in_if  din_if ();
  ctdi_out_if dout_if ();
  ctdi_cfg_if cfg_if ();

  convolutional_time_deinterleaver_core dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if),
    .cfg  (cfg_if)
  );

  always #1 clk = ~clk;

  // Shadow of the block: branch store image, counters, size register
  logic [15:0] branch_image [0:16*MAX_FRAG-1];
  branch_t     wr_branch = '0;
  bit [4:0]    fill_cnt = '0;
  int unsigned frag_pos = 0;
  cfg_size_t   frag_size_reg = cfg_size_t'(FRAG_RESET);

  soft_t       pending_bits [$];
  deint_res_t  due_results [$];
  int unsigned bits_queued = 0;
  int unsigned bits_taken = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          calm = 1'b0;
  int          mismatches = 0;

  // Write one bit into the current branch, read the bit-reversed branch back
  function automatic void deinterleave_bit(input soft_t bit_in);
    int unsigned span;
    int unsigned p;
    branch_t     rd;
    bit          at_end;
    deint_res_t  r;
    if (frag_size_reg == 0) span = 1;
    else if (frag_size_reg > MAX_FRAG) span = MAX_FRAG;
    else span = frag_size_reg;
    p = (frag_pos >= MAX_FRAG) ? MAX_FRAG - 1 : frag_pos;
    branch_image[{wr_branch, p[12:0]}] = bit_in;
    rd = wr_branch + branch_t'({p[0], p[1], p[2], p[3]});
    at_end = (frag_pos + 1 >= span);
    // fill phase: no result until 16 fragments are in
    if (fill_cnt == FILL_DONE) begin
      r.soft_bit_out = soft_t'(branch_image[{rd, p[12:0]}]);
      r.fragment_end = at_end;
      due_results.push_back(r);
    end
    if (at_end) begin
      frag_pos = 0;
      wr_branch = wr_branch + branch_t'(1);
      if (fill_cnt != FILL_DONE) fill_cnt = fill_cnt + 5'd1;
    end else begin
      frag_pos = frag_pos + 1;
    end
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  // Input driver: one item per transfer, random idle bursts between items
  always @(posedge clk) begin : feed
    logic  nxt_valid;
    soft_t nxt_bit;
    if (rst) begin
      din_if.valid <= 1'b0;
      din_if.soft_bit <= '0;
      in_gap <= 0;
    end else begin
      nxt_valid = din_if.valid;
      nxt_bit = din_if.soft_bit;
      if (din_if.valid && din_if.ready) begin
        deinterleave_bit(din_if.soft_bit);
        bits_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_bits.size() != 0) begin
          if (!calm && $urandom_range(15) == 0) begin
            in_gap <= $urandom_range(0, 13);
          end else begin
            nxt_valid = 1'b1;
            nxt_bit = pending_bits.pop_front();
          end
        end
      end
      din_if.valid <= nxt_valid;
      din_if.soft_bit <= nxt_bit;
    end
  end

  // Output monitor: compare each transfer with the oldest expected result
  always @(posedge clk) begin : watch
    deint_res_t want;
    if (rst) begin
      dout_if.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result %0d end %0b",
                                 dout_if.soft_bit_out, dout_if.fragment_end));
        end else begin
          want = due_results.pop_front();
          // an entry never written holds no defined value, so only the flag is checked
          if (!$isunknown(want.soft_bit_out) &&
              dout_if.soft_bit_out !== want.soft_bit_out)
            log_mismatch($sformatf("soft_bit_out expected %0d got %0d",
                                   want.soft_bit_out, dout_if.soft_bit_out));
          if (dout_if.fragment_end !== want.fragment_end)
            log_mismatch($sformatf("fragment_end expected %0b got %0b",
                                   want.fragment_end, dout_if.fragment_end));
        end
      end
      // random stall bursts on the result side
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        dout_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(15) == 0) begin
        out_gap <= $urandom_range(0, 13);
        dout_if.ready <= 1'b0;
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  function automatic soft_t pick_soft();
    case ($urandom_range(0, 15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return soft_t'($urandom);
    endcase
  endfunction

  // Mostly short fragments, now and then long or out-of-range ones
  function automatic cfg_size_t pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return cfg_size_t'($urandom_range(1, 24));
      6, 7:             return cfg_size_t'($urandom_range(25, 200));
      8:                return cfg_size_t'($urandom_range(201, 1000));
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return cfg_size_t'(15);
          2:       return cfg_size_t'(16);
          3:       return cfg_size_t'(MAX_FRAG);
          default: return cfg_size_t'($urandom_range(MAX_FRAG + 1, 16383));
        endcase
      end
    endcase
  endfunction

  task automatic write_frag_size(input cfg_size_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.fragment_size <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    frag_size_reg = v;
  endtask

  task automatic queue_bit(input soft_t v);
    pending_bits.push_back(v);
    bits_queued++;
  endtask

  // Wait for every queued bit and every expected result, then pipeline slack
  task automatic drain();
    do @(posedge clk);
    while (bits_taken != bits_queued || due_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(input cfg_size_t sz, input int unsigned n);
    write_frag_size(sz);
    repeat (n) queue_bit(pick_soft());
    drain();
  endtask

  // Stimulus sequence
  initial begin : stim
    cfg_size_t   sz;
    int unsigned n;
    int unsigned random_total;
    cfg_if.valid <= 1'b0;
    cfg_if.fragment_size <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // short fragments fill the first 16 positions of every branch, then some outputs
    run_random(cfg_size_t'(16), 16 * 16 + 8);

    // size zero acts as one and cuts the open fragment; later bits read themselves back
    write_frag_size('0);
    queue_bit(16'sh7FFF);
    queue_bit(16'sh8000);
    queue_bit('0);
    queue_bit('1);
    queue_bit(16'sh0001);
    queue_bit(16'sh5555);
    queue_bit(16'shAAAA);
    queue_bit(16'sh00FF);
    queue_bit(16'shFF00);
    queue_bit(16'shFFFE);
    drain();

    run_random(cfg_size_t'(1), 20);
    run_random(cfg_size_t'(16), 48);
    run_random(cfg_size_t'(17), 40);

    // all-ones size acts as the largest, so no fragment ends here
    run_random('1, 40);

    // random sizes and lengths, often ending mid-fragment
    random_total = 0;
    while (random_total < 160) begin
      sz = pick_size();
      n = $urandom_range(1, 2 * ((sz > 20) ? 20 : sz) + 8);
      run_random(sz, n);
      random_total += n;
    end

    // closing stretch at full rate
    calm = 1'b1;
    run_random(cfg_size_t'($urandom_range(2, 24)), 60);

    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("PASS convolutional_time_deinterleaver_core");
    end else begin
      $display("FAIL convolutional_time_deinterleaver_core");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #30_000_000;
    $display("FAIL convolutional_time_deinterleaver_core");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/ctdi_pkg.sv
design/ctdi_if.sv
design/ctdi_mem.sv
design/ctdi_ctrl.sv
design/convolutional_time_deinterleaver_core.sv
design/ctdi_checker.sv
bench/tb_convolutional_time_deinterleaver_core.sv
